FILE: sv/spl_pkg.sv
// ----------------------------------------------------------------------------
// spl_pkg - shared definitions for the stereo peak limiter
// Register indexes, fixed-point constants, sequencer states and the
// control/status structs of the serial divider.
// ----------------------------------------------------------------------------
package spl_pkg;

   // configuration register map
   localparam int CSR_IDX_BITS = 2;
   localparam int REG_BITS     = 24;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CEILING = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ATTACK  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELEASE = 2'd2;

   localparam logic [REG_BITS-1:0] CEILING_RESET = 24'd8388608;
   localparam logic [REG_BITS-1:0] ATTACK_RESET  = 24'd349525;
   localparam logic [REG_BITS-1:0] RELEASE_RESET = 24'd34953;

   // gain is unsigned Q2.23
   localparam int GAIN_BITS  = 25;
   localparam int GAIN_FRAC  = 23;
   localparam int SLOPE_BITS = 26;
   localparam int QUOT_BITS  = 23;

   localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 25'd8388608;
   localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 25'd16777216;

   // max change of slope per frame, 0.005 in Q.23
   localparam logic signed [SLOPE_BITS:0] SLOPE_STEP = 27'sd41943;
   localparam logic signed [SLOPE_BITS:0] SLOPE_HI   = 27'sd33554431;
   localparam logic signed [SLOPE_BITS:0] SLOPE_LO   = -27'sd33554432;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_ENV_MUL = 10'b00_0000_0010,
      ST_ENV_UPD = 10'b00_0000_0100,
      ST_TARGET  = 10'b00_0000_1000,
      ST_DIV     = 10'b00_0001_0000,
      ST_SLOPE   = 10'b00_0010_0000,
      ST_GAIN    = 10'b00_0100_0000,
      ST_MUL_L   = 10'b00_1000_0000,
      ST_MUL_R   = 10'b01_0000_0000,
      ST_FINISH  = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: sv/spl_if.sv
// ----------------------------------------------------------------------------
// spl_if - channel interfaces of the stereo peak limiter
// Request, response and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface spl_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface spl_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                              valid;
   logic                              ready;
   logic signed [SAMPLE_BITS-1:0]     left_out;
   logic signed [SAMPLE_BITS-1:0]     right_out;
   logic [spl_pkg::GAIN_BITS-1:0]     gain_now;

   modport source (output valid, output left_out, output right_out, output gain_now,
                   input ready);
   modport sink   (input valid, input left_out, input right_out, input gain_now,
                   output ready);
endinterface

interface spl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [spl_pkg::CSR_IDX_BITS-1:0] index;
   logic [spl_pkg::REG_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/spl_div.sv
// ----------------------------------------------------------------------------
// spl_div - serial restoring divider for the target gain
// Computes floor(dividend * 2^23 / divisor), one quotient bit per cycle.
// Requires dividend < divisor, so the quotient fits in 23 bits.
// ----------------------------------------------------------------------------
module spl_div #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  spl_pkg::div_ctrl_type            ctrl,
   input  logic [SAMPLE_BITS-1:0]           dividend,
   input  logic [SAMPLE_BITS-1:0]           divisor,
   output spl_pkg::div_stat_type            stat,
   output logic [spl_pkg::QUOT_BITS-1:0]    quotient
);

   localparam int CNT_BITS = $clog2(spl_pkg::QUOT_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(spl_pkg::QUOT_BITS - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0]        rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]        dsr_ff, dsr_in;
   logic [spl_pkg::QUOT_BITS-1:0] quot_ff, quot_in;
   logic [SAMPLE_BITS:0]          shifted;
   logic [SAMPLE_BITS:0]          trial;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_LAST;
         rem_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // restoring step: keep the trial remainder when it did not go negative
         if (!trial[SAMPLE_BITS]) begin
            rem_in  = trial[SAMPLE_BITS-1:0];
            quot_in = {quot_ff[spl_pkg::QUOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted[SAMPLE_BITS-1:0];
            quot_in = {quot_ff[spl_pkg::QUOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

FILE: sv/stereo_peak_limiter_slew_gain.sv
// ----------------------------------------------------------------------------
// stereo_peak_limiter_slew_gain - stereo peak limiter with slew-limited gain
// Envelope follower, ceiling/envelope gain target, second-order slew limit
// on the gain, and gain multiply with saturation on both channels.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one stereo frame per request (left_sample, right_sample).
//    req_ch.ready is high only while the sequencer is idle.
//  - rsp_ch returns one result per frame: both limited samples and the gain
//    that was applied. The result sits in an output register, so a stalled
//    receiver does not stop the next frame from being accepted and worked on;
//    only the final load waits for the output register to drain.
//  - csr_ch writes ceiling_level (0), attack_coef (1), release_coef (2);
//    other indexes are dropped. csr_ch.ready is always high. Write only idle.
// Sequence:
//  - A frame runs ENV_MUL, ENV_UPD, TARGET, SLOPE, GAIN, MUL_L, MUL_R and
//    FINISH; when the envelope is above the ceiling, DIV follows TARGET: the
//    target gain then comes from the serial divider, 23 quotient bits and then
//    the done flag. The next request is accepted once FINISH has loaded the
//    output register and the sequencer is back in IDLE.
//  - One shared multiplier does the envelope step and both gain products,
//    one product per cycle except while FINISH waits on a stall, under the state sequencer.
// Reset (synchronous, active high): registers back to their defaults,
//  envelope zero, gain unity, slope zero, output empty.
// ----------------------------------------------------------------------------
module stereo_peak_limiter_slew_gain #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic      clock,
   input  logic      reset,
   spl_req_if.sink   req_ch,
   spl_rsp_if.source rsp_ch,
   spl_csr_if.sink   csr_ch
);

   localparam int RB = spl_pkg::REG_BITS;
   localparam int GB = spl_pkg::GAIN_BITS;
   localparam int SB = spl_pkg::SLOPE_BITS;
   // shared multiplier: signed (SAMPLE_BITS+1) x signed (SLOPE_BITS)
   localparam int PW = SAMPLE_BITS + 1 + SB;
   localparam int QW = PW - spl_pkg::GAIN_FRAC;

   localparam logic [SAMPLE_BITS-1:0] ENV_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // ---------------- configuration registers ----------------
   logic [RB-1:0] ceiling_ff, ceiling_in;
   logic [RB-1:0] attack_ff, attack_in;
   logic [RB-1:0] release_ff, release_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      ceiling_in = ceiling_ff;
      attack_in  = attack_ff;
      release_in = release_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            spl_pkg::CSR_CEILING: ceiling_in = csr_ch.data;
            spl_pkg::CSR_ATTACK:  attack_in  = csr_ch.data;
            spl_pkg::CSR_RELEASE: release_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   // ceiling moved to sample scale: ceiling * 2^SAMPLE_BITS / 2^24, truncated
   logic [SAMPLE_BITS+RB-1:0] ceil_wide;
   logic [SAMPLE_BITS-1:0]    ceil_s;
   assign ceil_wide = {ceiling_ff, {SAMPLE_BITS{1'b0}}};
   assign ceil_s    = ceil_wide[SAMPLE_BITS+RB-1:RB];

   // ---------------- sequencer and datapath state ----------------
   spl_pkg::state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] left_ff, left_in;
   logic signed [SAMPLE_BITS-1:0] right_ff, right_in;
   logic [SAMPLE_BITS-1:0]        diff_ff, diff_in;
   logic                          up_ff, up_in;
   logic [SAMPLE_BITS-1:0]        env_ff, env_in;
   logic [GB-1:0]                 target_ff, target_in;
   logic signed [SB-1:0]          slope_ff, slope_in;
   logic [GB-1:0]                 gain_ff, gain_in;
   logic signed [PW-1:0]          prod_ff;
   logic signed [SAMPLE_BITS-1:0] lres_ff, lres_in;

   // output register
   logic                          ovalid_ff, ovalid_in;
   logic signed [SAMPLE_BITS-1:0] oleft_ff, oleft_in;
   logic signed [SAMPLE_BITS-1:0] oright_ff, oright_in;
   logic [GB-1:0]                 ogain_ff, ogain_in;

   logic req_take;
   logic out_free;
   assign req_ch.ready = (state_ff == spl_pkg::ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !ovalid_ff || rsp_ch.ready;

   // magnitude as unsigned; full-scale negative maps to 2^(SAMPLE_BITS-1)
   logic [SAMPLE_BITS-1:0] mag_l, mag_r, peak;
   assign mag_l = req_ch.left_sample[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-req_ch.left_sample)
                                                     : SAMPLE_BITS'(req_ch.left_sample);
   assign mag_r = req_ch.right_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-req_ch.right_sample)
                                                     : SAMPLE_BITS'(req_ch.right_sample);
   assign peak  = (mag_l > mag_r) ? mag_l : mag_r;

   // ---------------- shared multiplier ----------------
   logic signed [SAMPLE_BITS:0] mul_a;
   logic signed [SB-1:0]        mul_b;
   logic signed [PW-1:0]        mul_p;

   always_comb begin
      mul_a = {1'b0, diff_ff};
      mul_b = $signed({{(SB-RB){1'b0}}, (up_ff ? attack_ff : release_ff)});
      if (state_ff == spl_pkg::ST_MUL_L) begin
         mul_a = {left_ff[SAMPLE_BITS-1], left_ff};
         mul_b = $signed({{(SB-GB){1'b0}}, gain_ff});
      end else if (state_ff == spl_pkg::ST_MUL_R) begin
         mul_a = {right_ff[SAMPLE_BITS-1], right_ff};
         mul_b = $signed({{(SB-GB){1'b0}}, gain_ff});
      end
   end

   assign mul_p = PW'(mul_a) * PW'(mul_b);

   // product >> 23 with floor rounding, saturated to the sample range
   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [PW-1:0] p);
      logic signed [QW-1:0] q;
      logic signed [QW-1:0] qmax;
      logic signed [QW-1:0] qmin;
      q    = QW'(p >>> spl_pkg::GAIN_FRAC);
      qmax = {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
      qmin = {{(QW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
      if (q > qmax)
         round_sat = qmax[SAMPLE_BITS-1:0];
      else if (q < qmin)
         round_sat = qmin[SAMPLE_BITS-1:0];
      else
         round_sat = q[SAMPLE_BITS-1:0];
   endfunction

   // ---------------- divider ----------------
   spl_pkg::div_ctrl_type       div_ctrl;
   spl_pkg::div_stat_type       div_stat;
   logic [spl_pkg::QUOT_BITS-1:0] div_quot;
   logic                        env_over;

   assign env_over       = env_ff > ceil_s;
   assign div_ctrl.start = (state_ff == spl_pkg::ST_TARGET) && env_over;

   spl_div #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (ceil_s),
      .divisor  (env_ff),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // ---------------- slew arithmetic ----------------
   logic signed [SB:0]   want, slope_lo, slope_hi, slope_sel;
   logic signed [SB+1:0] gain_sum;
   logic [SAMPLE_BITS-1:0] env_delta;

   assign env_delta = prod_ff[SAMPLE_BITS+RB-1:RB];
   assign want      = $signed({2'b00, target_ff}) - $signed({2'b00, gain_ff});
   assign slope_lo  = (SB+1)'(slope_ff) - spl_pkg::SLOPE_STEP;
   assign slope_hi  = (SB+1)'(slope_ff) + spl_pkg::SLOPE_STEP;
   assign gain_sum  = $signed({3'b000, gain_ff}) + (SB+2)'(slope_ff);

   always_comb begin
      if (want < slope_lo)
         slope_sel = slope_lo;
      else if (want > slope_hi)
         slope_sel = slope_hi;
      else
         slope_sel = want;
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      diff_in   = diff_ff;
      up_in     = up_ff;
      env_in    = env_ff;
      target_in = target_ff;
      slope_in  = slope_ff;
      gain_in   = gain_ff;
      lres_in   = lres_ff;
      ovalid_in = ovalid_ff && !rsp_ch.ready;
      oleft_in  = oleft_ff;
      oright_in = oright_ff;
      ogain_in  = ogain_ff;

      unique case (state_ff)
         spl_pkg::ST_IDLE: begin
            if (req_take) begin
               left_in  = req_ch.left_sample;
               right_in = req_ch.right_sample;
               up_in    = peak > env_ff;
               diff_in  = (peak > env_ff) ? (peak - env_ff) : (env_ff - peak);
               state_in = spl_pkg::ST_ENV_MUL;
            end
         end
         spl_pkg::ST_ENV_MUL: state_in = spl_pkg::ST_ENV_UPD;
         spl_pkg::ST_ENV_UPD: begin
            // floor of the step, so the envelope never passes the peak
            env_in   = up_ff ? (env_ff + env_delta) : (env_ff - env_delta);
            state_in = spl_pkg::ST_TARGET;
         end
         spl_pkg::ST_TARGET: begin
            if (env_over) begin
               state_in = spl_pkg::ST_DIV;
            end else begin
               target_in = spl_pkg::GAIN_UNITY;
               state_in  = spl_pkg::ST_SLOPE;
            end
         end
         spl_pkg::ST_DIV: begin
            if (div_stat.done) begin
               target_in = {{(GB-spl_pkg::QUOT_BITS){1'b0}}, div_quot};
               state_in  = spl_pkg::ST_SLOPE;
            end
         end
         spl_pkg::ST_SLOPE: begin
            if (slope_sel > spl_pkg::SLOPE_HI)
               slope_in = spl_pkg::SLOPE_HI[SB-1:0];
            else if (slope_sel < spl_pkg::SLOPE_LO)
               slope_in = spl_pkg::SLOPE_LO[SB-1:0];
            else
               slope_in = slope_sel[SB-1:0];
            state_in = spl_pkg::ST_GAIN;
         end
         spl_pkg::ST_GAIN: begin
            if (gain_sum < 0)
               gain_in = '0;
            else if (gain_sum > $signed({3'b000, spl_pkg::GAIN_MAX}))
               gain_in = spl_pkg::GAIN_MAX;
            else
               gain_in = gain_sum[GB-1:0];
            state_in = spl_pkg::ST_MUL_L;
         end
         spl_pkg::ST_MUL_L: state_in = spl_pkg::ST_MUL_R;
         spl_pkg::ST_MUL_R: begin
            lres_in  = round_sat(prod_ff);
            state_in = spl_pkg::ST_FINISH;
         end
         spl_pkg::ST_FINISH: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               oleft_in  = lres_ff;
               oright_in = round_sat(prod_ff);
               ogain_in  = gain_ff;
               state_in  = spl_pkg::ST_IDLE;
            end
         end
         default: state_in = spl_pkg::ST_IDLE;
      endcase
   end

   // prod_ff must hold the right product while FINISH waits on a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= spl_pkg::CEILING_RESET;
         attack_ff  <= spl_pkg::ATTACK_RESET;
         release_ff <= spl_pkg::RELEASE_RESET;
         state_ff   <= spl_pkg::ST_IDLE;
         env_ff     <= '0;
         gain_ff    <= spl_pkg::GAIN_UNITY;
         slope_ff   <= '0;
         ovalid_ff  <= 1'b0;
      end else begin
         ceiling_ff <= ceiling_in;
         attack_ff  <= attack_in;
         release_ff <= release_in;
         state_ff   <= state_in;
         env_ff     <= env_in;
         gain_ff    <= gain_in;
         slope_ff   <= slope_in;
         ovalid_ff  <= ovalid_in;
      end
      left_ff   <= left_in;
      right_ff  <= right_in;
      diff_ff   <= diff_in;
      up_ff     <= up_in;
      target_ff <= target_in;
      lres_ff   <= lres_in;
      oleft_ff  <= oleft_in;
      oright_ff <= oright_in;
      ogain_ff  <= ogain_in;
      if (state_ff != spl_pkg::ST_FINISH)
         prod_ff <= mul_p;
   end

   assign rsp_ch.valid     = ovalid_ff;
   assign rsp_ch.left_out  = oleft_ff;
   assign rsp_ch.right_out = oright_ff;
   assign rsp_ch.gain_now  = ogain_ff;

   // ---------------- assertions ----------------
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= spl_pkg::GAIN_MAX)
      else $error("gain above 2.0");

   a_env_range: assert property (@(posedge clock) disable iff (reset)
      env_ff <= ENV_MAX)
      else $error("envelope above full scale");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == spl_pkg::ST_ENV_MUL)
      else $error("accepted request did not start the sequencer");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == spl_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

   a_div_only_over: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spl_pkg::ST_DIV) |-> env_ff > ceil_s)
      else $error("divide state with envelope at or below ceiling");

   a_div_busy_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == spl_pkg::ST_DIV)
      else $error("divider busy outside the divide state");

endmodule
